// ===== rtl/rce_pkg.sv =====
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types, register codes, reset values and the quadrature decode table
// for the rotary encoder and click decoder.
// ----------------------------------------------------------------------------
package rce_pkg;

  // Parameter defaults
  localparam int TIME_BITS_DEF = 32;
  localparam int POS_BITS_DEF  = 16;

  // Fixed field widths
  localparam int STAMP_W    = 32;
  localparam int POS_W      = 16;
  localparam int DIR_W      = 2;
  localparam int CLICK_W    = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 88;
  localparam int M_TDATA_W  = 24;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_QUAD_MODE    = 3'd0,
    REG_INVERT_DIR   = 3'd1,
    REG_LOCKOUT_US   = 3'd2,
    REG_CLICK_GAP_MS = 3'd3,
    REG_LONG_HOLD_MS = 3'd4
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic                  QUAD_MODE_RST    = 1'b1;
  localparam logic                  INVERT_DIR_RST   = 1'b0;
  localparam logic [CFG_DATA_W-1:0] LOCKOUT_US_RST   = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] CLICK_GAP_MS_RST = 16'd300;
  localparam logic [CFG_DATA_W-1:0] LONG_HOLD_MS_RST = 16'd1000;

  // Item kinds carried in tuser
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // Step directions
  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_DOWN = 2'sb11;

  // Click tally limit
  localparam logic [CLICK_W-1:0] TALLY_MAX = 2'd3;

  // Quadrature table, indexed by {previous AB, current AB}
  localparam logic signed [DIR_W-1:0] QUAD_TABLE [16] = '{
    DIR_NONE, DIR_DOWN, DIR_UP,   DIR_NONE,
    DIR_UP,   DIR_NONE, DIR_NONE, DIR_DOWN,
    DIR_DOWN, DIR_NONE, DIR_NONE, DIR_UP,
    DIR_NONE, DIR_UP,   DIR_DOWN, DIR_NONE
  };

  typedef struct packed {
    logic                  quad_mode;
    logic                  invert_dir;
    logic [CFG_DATA_W-1:0] lockout_us;
    logic [CFG_DATA_W-1:0] click_gap_ms;
    logic [CFG_DATA_W-1:0] long_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic                    func;
    logic                    pin_a;
    logic                    pin_b;
    logic                    pin_sw;
    logic [STAMP_W-1:0]      now_us;
    logic [STAMP_W-1:0]      now_ms;
    logic signed [POS_W-1:0] new_position;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [DIR_W-1:0] step_dir;
    logic [CLICK_W-1:0]      clicks;
    logic                    long_press;
  } result_t;

endpackage

// ===== rtl/rce_cfg.sv =====
// ----------------------------------------------------------------------------
// rce_cfg
// Configuration register file: write-only, indexed, with reset defaults.
// ----------------------------------------------------------------------------
module rce_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rce_pkg::cfg_t                  cfg
);

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quad_mode    <= rce_pkg::QUAD_MODE_RST;
      cfg.invert_dir   <= rce_pkg::INVERT_DIR_RST;
      cfg.lockout_us   <= rce_pkg::LOCKOUT_US_RST;
      cfg.click_gap_ms <= rce_pkg::CLICK_GAP_MS_RST;
      cfg.long_hold_ms <= rce_pkg::LONG_HOLD_MS_RST;
    end else if (cfg_we) begin
      case (rce_pkg::cfg_reg_t'(cfg_addr))
        rce_pkg::REG_QUAD_MODE:    cfg.quad_mode    <= cfg_wdata[0];
        rce_pkg::REG_INVERT_DIR:   cfg.invert_dir   <= cfg_wdata[0];
        rce_pkg::REG_LOCKOUT_US:   cfg.lockout_us   <= cfg_wdata;
        rce_pkg::REG_CLICK_GAP_MS: cfg.click_gap_ms <= cfg_wdata;
        rce_pkg::REG_LONG_HOLD_MS: cfg.long_hold_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rce_core.sv =====
// ----------------------------------------------------------------------------
// rce_core
// Decoder state and its single-pass update: quadrature or A-edge decode with
// time lockout, position counter, click sequencing and long-hold detection.
// ----------------------------------------------------------------------------
module rce_core #(
  parameter int TIME_BITS = rce_pkg::TIME_BITS_DEF,
  parameter int POS_BITS  = rce_pkg::POS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rce_pkg::cfg_t    cfg,
  input  rce_pkg::item_t   item,
  input  logic             fire,
  output rce_pkg::result_t result
);

  logic [POS_BITS-1:0]              count_reg, count_next;
  logic [1:0]                       prev_ab, prev_ab_next;
  logic                             prev_a, prev_a_next;
  logic [TIME_BITS-1:0]             edge_time_us, edge_time_us_next;
  logic                             prev_sw, prev_sw_next;
  logic [TIME_BITS-1:0]             press_time_ms, press_time_ms_next;
  logic                             press_timed, press_timed_next;
  logic                             long_seen, long_seen_next;
  logic                             held_long, held_long_next;
  logic [TIME_BITS-1:0]             release_time_ms, release_time_ms_next;
  logic [rce_pkg::CLICK_W-1:0]      click_tally, click_tally_next;

  logic [TIME_BITS-1:0]             now_us_t, now_ms_t;
  logic [1:0]                       ab;
  logic                             lockout_open;
  logic                             window_gone;
  logic                             hold_passed;
  logic                             poll_expired;
  logic signed [rce_pkg::DIR_W-1:0] dir;
  logic [rce_pkg::CLICK_W-1:0]      clicks;
  logic                             longp;

  // Timestamps at the internal time width, and the elapsed-time compares
  assign now_us_t     = TIME_BITS'(item.now_us);
  assign now_ms_t     = TIME_BITS'(item.now_ms);
  assign ab           = {item.pin_a, item.pin_b};
  assign lockout_open = (now_us_t - edge_time_us) > TIME_BITS'(cfg.lockout_us);
  assign window_gone  = (now_ms_t - release_time_ms) > TIME_BITS'(cfg.click_gap_ms);
  assign hold_passed  = (now_ms_t - press_time_ms) > TIME_BITS'(cfg.long_hold_ms);

  // Next state and result for the item at the input register
  always_comb begin
    count_next           = count_reg;
    prev_ab_next         = prev_ab;
    prev_a_next          = prev_a;
    edge_time_us_next    = edge_time_us;
    prev_sw_next         = prev_sw;
    press_time_ms_next   = press_time_ms;
    press_timed_next     = press_timed;
    long_seen_next       = long_seen;
    held_long_next       = held_long;
    release_time_ms_next = release_time_ms;
    click_tally_next     = click_tally;
    poll_expired         = 1'b0;
    dir                  = rce_pkg::DIR_NONE;
    clicks               = '0;
    longp                = 1'b0;

    if (item.func == rce_pkg::FUNC_LOAD) begin
      count_next = POS_BITS'(item.new_position);
    end else begin
      // Movement decode
      if (cfg.quad_mode) begin
        if (ab != prev_ab && lockout_open) begin
          dir               = rce_pkg::QUAD_TABLE[{prev_ab, ab}];
          prev_ab_next      = ab;
          edge_time_us_next = now_us_t;
        end
      end else if (item.pin_a != prev_a && lockout_open) begin
        dir               = (item.pin_b != item.pin_a) ? rce_pkg::DIR_UP : rce_pkg::DIR_DOWN;
        prev_a_next       = item.pin_a;
        prev_ab_next      = ab;
        edge_time_us_next = now_us_t;
      end

      // Position follows the uninverted step
      if (dir == rce_pkg::DIR_UP) begin
        count_next = count_reg + POS_BITS'(1);
      end else if (dir == rce_pkg::DIR_DOWN) begin
        count_next = count_reg - POS_BITS'(1);
      end

      // Switch release: end of press, count clicks
      if (item.pin_sw && !prev_sw) begin
        long_seen_next     = 1'b0;
        press_timed_next   = 1'b0;
        press_time_ms_next = '0;
        if (held_long) begin
          held_long_next       = 1'b0;
          click_tally_next     = '0;
          release_time_ms_next = '0;
        end else if (click_tally == '0 || window_gone) begin
          click_tally_next     = rce_pkg::CLICK_W'(1);
          release_time_ms_next = now_ms_t;
        end else begin
          if (click_tally < rce_pkg::TALLY_MAX) begin
            click_tally_next = click_tally + rce_pkg::CLICK_W'(1);
          end
          release_time_ms_next = now_ms_t;
        end
      end

      // Switch press: start timing
      if (!item.pin_sw && prev_sw) begin
        press_time_ms_next = now_ms_t;
        press_timed_next   = 1'b1;
      end

      // Held press crossing the long-hold time
      if (!item.pin_sw && !prev_sw && press_timed && !long_seen && hold_passed) begin
        long_seen_next = 1'b1;
        held_long_next = 1'b1;
        longp          = 1'b1;
      end
      prev_sw_next = item.pin_sw;

      // Report a finished click sequence; the window runs from the release
      // time after the switch update
      poll_expired = (now_ms_t - release_time_ms_next) > TIME_BITS'(cfg.click_gap_ms);
      if (click_tally_next != '0 && poll_expired) begin
        clicks               = click_tally_next;
        click_tally_next     = '0;
        release_time_ms_next = '0;
      end

      if (cfg.invert_dir) begin
        dir = -dir;
      end
    end

    result.position   = rce_pkg::POS_W'(count_next);
    result.step_dir   = dir;
    result.clicks     = clicks;
    result.long_press = longp;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg       <= '0;
      prev_ab         <= 2'b11;
      prev_a          <= 1'b1;
      edge_time_us    <= '0;
      prev_sw         <= 1'b1;
      press_time_ms   <= '0;
      press_timed     <= 1'b0;
      long_seen       <= 1'b0;
      held_long       <= 1'b0;
      release_time_ms <= '0;
      click_tally     <= '0;
    end else if (fire) begin
      count_reg       <= count_next;
      prev_ab         <= prev_ab_next;
      prev_a          <= prev_a_next;
      edge_time_us    <= edge_time_us_next;
      prev_sw         <= prev_sw_next;
      press_time_ms   <= press_time_ms_next;
      press_timed     <= press_timed_next;
      long_seen       <= long_seen_next;
      held_long       <= held_long_next;
      release_time_ms <= release_time_ms_next;
      click_tally     <= click_tally_next;
    end
  end

  // A position load lands in the counter
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    fire && item.func == rce_pkg::FUNC_LOAD
      |=> count_reg == POS_BITS'($past(item.new_position)))
    else $error("position load not taken");

  // A position load reports no events
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    fire && item.func == rce_pkg::FUNC_LOAD
      |-> result.step_dir == rce_pkg::DIR_NONE && result.clicks == '0 && !result.long_press)
    else $error("position load reported an event");

  // Long-hold pulse arms the hold flags
  a_long_flags: assert property (@(posedge clk) disable iff (rst)
    fire && result.long_press |=> held_long && long_seen)
    else $error("long hold flags not set");

  // A reported sequence clears the tally
  a_click_clear: assert property (@(posedge clk) disable iff (rst)
    fire && result.clicks != '0 |=> click_tally == '0 && release_time_ms == '0)
    else $error("click tally not cleared after report");

endmodule

// ===== rtl/rotary_encoder_click_decoder.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_click_decoder
// Top level: input register, decoder core, result register, config port.
// ----------------------------------------------------------------------------
// One result beat per input beat, in order. A sample is captured in the
// input register, decoded in one pass by the core and written to the result
// register. A new beat is taken every cycle; the only limit is the result
// register, which holds when m_tready is low. A beat with tuser set loads
// new_position into the counter and reports no movement, clicks or long
// press. The user must write configuration by index through cfg_we/
// cfg_addr/cfg_wdata only while no beats are in flight; it is not enforced.
// ----------------------------------------------------------------------------
module rotary_encoder_click_decoder #(
  parameter int TIME_BITS = rce_pkg::TIME_BITS_DEF,
  parameter int POS_BITS  = rce_pkg::POS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pin_a[0], pin_b[1], pin_sw[2], now_us[34:3], now_ms[66:35],
  // new_position[82:67], zero fill[87:83]
  input  logic [rce_pkg::S_TDATA_W-1:0]  s_tdata,
  // func[0]: 0 pin sample, 1 position load
  input  logic                           s_tuser,
  // Result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // position[15:0], step_dir[17:16], clicks[19:18], long_press[20],
  // zero fill[23:21]
  output logic [rce_pkg::M_TDATA_W-1:0]  m_tdata,
  // Configuration
  input  logic                           cfg_we,
  input  logic [rce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rce_pkg::cfg_t    cfg;
  rce_pkg::item_t   s_item;
  rce_pkg::item_t   in_item;
  logic             in_valid;
  rce_pkg::result_t core_result;
  rce_pkg::result_t out_result;
  logic             out_valid;
  logic             out_free;
  logic             fire;

  // Unpack the input beat
  always_comb begin
    s_item.func         = s_tuser;
    s_item.pin_a        = s_tdata[0];
    s_item.pin_b        = s_tdata[1];
    s_item.pin_sw       = s_tdata[2];
    s_item.now_us       = s_tdata[34:3];
    s_item.now_ms       = s_tdata[66:35];
    s_item.new_position = s_tdata[82:67];
  end

  // Pipeline flow
  assign out_free = !out_valid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

  rce_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rce_core #(
    .TIME_BITS (TIME_BITS),
    .POS_BITS  (POS_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (in_item),
    .fire   (fire),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= core_result;
    end
  end

  // Pack the result beat
  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_result.long_press, out_result.clicks,
                     out_result.step_dir, out_result.position};

endmodule
